/* design/markov_note_sampler_assert.svh */
// assertion macros used by the checker of the note sampler
`ifndef MARKOV_NOTE_SAMPLER_ASSERT_SVH
`define MARKOV_NOTE_SAMPLER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("note sampler check failed");

// next-cycle implication, clocked on clk, off during reset
`define MNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("note sampler check failed");

`endif

/* design/mns_pkg.sv */
package mns_pkg;

  // request codes
  typedef logic [2:0] req_t;

  localparam req_t REQ_WR_NOTE  = 3'd0;
  localparam req_t REQ_WR_WT    = 3'd1;
  localparam req_t REQ_STEP     = 3'd2;
  localparam req_t REQ_REINF    = 3'd3;
  localparam req_t REQ_SET_NOTE = 3'd4;
  localparam req_t REQ_FILL     = 3'd5;
  localparam req_t REQ_BAD_A    = 3'd6;
  localparam req_t REQ_BAD_B    = 3'd7;

  // note shown when the current state is not below the active count
  localparam logic [6:0] NOTE_DFLT = 7'd60;

endpackage

/* design/mns_ram.sv */
module mns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/markov_note_sampler.sv */
// sequence: write note, write weight and unknown requests pass S_NOTERD and S_OUT only;
//   step and set-by-note scan a row or the note table by column, fill divides and then
//   sweeps the weight RAM, reinforce updates an entry, sums its row and divides each entry
//   by the sum (or writes a uniform row); one request at a time, paced by the bit-serial
//   divider and the weight RAM; the receiver cannot stall
// reset: synchronous, active low; then busy sweeping uniform weights
module markov_note_sampler #(
  parameter int MAX_STATES  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_from_index,
  input  logic [3:0]  in_to_index,
  input  logic [15:0] in_weight_value,
  input  logic [15:0] in_random_fraction,
  input  logic [6:0]  in_note_value,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [3:0]  out_state_index,
  output logic [6:0]  out_current_note,
  output logic        out_status
);

  localparam int WB   = WEIGHT_BITS;
  localparam int SW   = $clog2(MAX_STATES);
  localparam int NW   = $clog2(MAX_STATES + 1);
  localparam int AW   = 2 * SW;
  localparam int SUMW = WB + SW;
  localparam int QW   = WB + 1;
  localparam int DCW  = $clog2(QW + 1);
  localparam int NRST = (MAX_STATES < 16) ? MAX_STATES : 16;
  localparam logic [SUMW-1:0] SUM_MIN = SUMW'((64'd1 << WEIGHT_BITS) / 10000);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_UDIV    = 5'd1;
  localparam logic [4:0] S_UNIX    = 5'd2;
  localparam logic [4:0] S_FILL    = 5'd3;
  localparam logic [4:0] S_UNIWR   = 5'd4;
  localparam logic [4:0] S_STEPRD  = 5'd5;
  localparam logic [4:0] S_STEPCHK = 5'd6;
  localparam logic [4:0] S_RFRD    = 5'd7;
  localparam logic [4:0] S_RFWR    = 5'd8;
  localparam logic [4:0] S_SUMRD   = 5'd9;
  localparam logic [4:0] S_SUMACC  = 5'd10;
  localparam logic [4:0] S_NRMRD   = 5'd11;
  localparam logic [4:0] S_NRMLD   = 5'd12;
  localparam logic [4:0] S_NDIV    = 5'd13;
  localparam logic [4:0] S_NRMWR   = 5'd14;
  localparam logic [4:0] S_SRCHRD  = 5'd15;
  localparam logic [4:0] S_SRCHCHK = 5'd16;
  localparam logic [4:0] S_NOTERD  = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  logic [4:0]            state_r, state_nxt;
  logic [4:0]            num_states_r;
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         prev_r, prev_nxt;
  logic [SW-1:0]         col_r, col_nxt;
  logic [AW-1:0]         fill_r, fill_nxt;
  mns_pkg::req_t         req_r, req_nxt;
  logic [WB-1:0]         wv_r, wv_nxt;
  logic [15:0]           rf_r, rf_nxt;
  logic [6:0]            note_r, note_nxt;
  logic [SUMW-1:0]       acc_r, acc_nxt;
  logic [WB-1:0]         uni_r, uni_nxt;
  logic                  status_r, status_nxt;
  logic                  rstp_r, rstp_nxt;
  logic [MAX_STATES-1:0] note_vld_r, note_vld_nxt;
  logic [SUMW-1:0]       rem_r, rem_nxt;
  logic [QW-1:0]         lo_r, lo_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [SUMW-1:0]       dvs_r, dvs_nxt;
  logic [DCW-1:0]        dcnt_r, dcnt_nxt;

  logic [NW-1:0]         n_eff;
  logic                  col_last;
  logic                  cur_ok;
  logic                  prev_ok;
  logic [WB+15:0]        sc_wide;
  logic [WB-1:0]         wv_scaled;
  logic [WB-1:0]         q_sat;
  logic [SUMW:0]         div_t;
  logic                  div_ge;
  logic [WB:0]           rf_sum;
  logic [WB-1:0]         rf_wt;
  logic [SUMW-1:0]       cum;
  logic                  step_hit;
  logic [6:0]            note_seen;

  logic                  w_we;
  logic [AW-1:0]         w_waddr, w_raddr;
  logic [WB-1:0]         w_wdata, w_rdata;
  logic                  n_we;
  logic [SW-1:0]         n_waddr, n_raddr;
  logic [6:0]            n_rdata;

  // active state count, clamped to 1..MAX_STATES
  always_comb begin
    if (num_states_r == 5'd0) begin
      n_eff = NW'(1);
    end else if (32'(num_states_r) > MAX_STATES) begin
      n_eff = NW'(MAX_STATES);
    end else begin
      n_eff = NW'(num_states_r);
    end
  end

  assign col_last = (32'(col_r) == 32'(n_eff) - 32'd1);
  assign cur_ok   = (32'(cur_r) < 32'(n_eff));
  assign prev_ok  = (32'(prev_r) < 32'(n_eff));

  // q0.16 input weight to the internal weight scale
  assign sc_wide   = {in_weight_value, {WB{1'b0}}} >> 16;
  assign wv_scaled = sc_wide[WB-1:0];

  // shared restoring divider step: one quotient bit per cycle
  assign div_t  = {rem_r, lo_r[QW-1]};
  assign div_ge = (div_t >= {1'b0, dvs_r});
  assign q_sat  = q_r[WB] ? {WB{1'b1}} : q_r[WB-1:0];

  // reinforcement add with saturation
  assign rf_sum = {1'b0, w_rdata} + {1'b0, wv_r};
  assign rf_wt  = rf_sum[WB] ? {WB{1'b1}} : rf_sum[WB-1:0];

  // running sum and threshold test of a step
  assign cum      = acc_r + SUMW'(w_rdata);
  assign step_hit = ((SUMW+16)'({rf_r, {WB{1'b0}}}) < {cum, 16'd0});

  // note read, never-written entries read as zero
  assign note_seen = (state_r == S_SRCHCHK) ?
                     (note_vld_r[col_r] ? n_rdata : 7'd0) :
                     (note_vld_r[cur_r] ? n_rdata : 7'd0);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    col_nxt      = col_r;
    fill_nxt     = fill_r;
    req_nxt      = req_r;
    wv_nxt       = wv_r;
    rf_nxt       = rf_r;
    note_nxt     = note_r;
    acc_nxt      = acc_r;
    uni_nxt      = uni_r;
    status_nxt   = status_r;
    rstp_nxt     = rstp_r;
    note_vld_nxt = note_vld_r;
    rem_nxt      = rem_r;
    lo_nxt       = lo_r;
    q_nxt        = q_r;
    dvs_nxt      = dvs_r;
    dcnt_nxt     = dcnt_r;
    w_we         = 1'b0;
    w_waddr      = {prev_r, col_r};
    w_wdata      = uni_r;
    w_raddr      = {prev_r, col_r};
    n_we         = 1'b0;
    n_waddr      = SW'(in_from_index);
    n_raddr      = cur_r;

    unique case (state_r) inside
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req_type;
          status_nxt = 1'b0;
          col_nxt    = '0;
          acc_nxt    = '0;
          state_nxt  = S_NOTERD;
          case (in_req_type)
            mns_pkg::REQ_WR_NOTE: begin
              if (32'(in_from_index) < 32'(n_eff)) begin
                n_we = 1'b1;
                note_vld_nxt[SW'(in_from_index)] = 1'b1;
              end else begin
                status_nxt = 1'b1;
              end
            end
            mns_pkg::REQ_WR_WT: begin
              if (32'(in_from_index) < 32'(n_eff) && 32'(in_to_index) < 32'(n_eff)) begin
                w_we    = 1'b1;
                w_waddr = {SW'(in_from_index), SW'(in_to_index)};
                w_wdata = wv_scaled;
              end else begin
                status_nxt = 1'b1;
              end
            end
            mns_pkg::REQ_STEP: begin
              if (cur_ok) begin
                prev_nxt  = cur_r;
                rf_nxt    = in_random_fraction;
                state_nxt = S_STEPRD;
              end else begin
                status_nxt = 1'b1;
              end
            end
            mns_pkg::REQ_REINF: begin
              if (cur_ok && prev_ok) begin
                wv_nxt    = wv_scaled;
                state_nxt = S_RFRD;
              end else begin
                status_nxt = 1'b1;
              end
            end
            mns_pkg::REQ_SET_NOTE: begin
              note_nxt  = in_note_value;
              state_nxt = S_SRCHRD;
            end
            mns_pkg::REQ_FILL: begin
              rem_nxt   = '0;
              lo_nxt    = {1'b1, {WB{1'b0}}};
              dvs_nxt   = SUMW'(n_eff);
              dcnt_nxt  = DCW'(QW);
              state_nxt = S_UDIV;
            end
            default: begin
              status_nxt = 1'b1;
            end
          endcase
        end
      end

      // divider: one over n for a uniform weight, or an entry over the row sum when normalising
      S_UDIV, S_NDIV: begin
        rem_nxt  = div_ge ? SUMW'(div_t - {1'b0, dvs_r}) : div_t[SUMW-1:0];
        q_nxt    = {q_r[QW-2:0], div_ge};
        lo_nxt   = {lo_r[QW-2:0], 1'b0};
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          state_nxt = (state_r == S_UDIV) ? S_UNIX : S_NRMWR;
        end
      end

      S_UNIX: begin
        uni_nxt  = q_sat;
        fill_nxt = '0;
        col_nxt  = '0;
        state_nxt = (req_r == mns_pkg::REQ_FILL) ? S_FILL : S_UNIWR;
      end

      // sweep the whole weight RAM
      S_FILL: begin
        w_we     = 1'b1;
        w_waddr  = fill_r;
        fill_nxt = fill_r + AW'(1);
        if (fill_r == {AW{1'b1}}) begin
          cur_nxt  = '0;
          prev_nxt = '0;
          if (rstp_r) begin
            rstp_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_NOTERD;
          end
        end
      end

      // uniform row after a too-small sum
      S_UNIWR: begin
        w_we = 1'b1;
        if (col_last) begin
          state_nxt = S_NOTERD;
        end else begin
          col_nxt = col_r + SW'(1);
        end
      end

      // step: accumulate the current row until it passes the fraction or the row ends
      S_STEPRD: begin
        w_raddr   = {cur_r, col_r};
        state_nxt = S_STEPCHK;
      end
      S_STEPCHK: begin
        acc_nxt = cum;
        if (step_hit || col_last) begin
          cur_nxt   = col_r;
          state_nxt = S_NOTERD;
        end else begin
          col_nxt   = col_r + SW'(1);
          state_nxt = S_STEPRD;
        end
      end

      // reinforce the last transition
      S_RFRD: begin
        w_raddr   = {prev_r, cur_r};
        state_nxt = S_RFWR;
      end
      S_RFWR: begin
        w_we      = 1'b1;
        w_waddr   = {prev_r, cur_r};
        w_wdata   = rf_wt;
        state_nxt = S_SUMRD;
      end

      // row sum
      S_SUMRD: begin
        state_nxt = S_SUMACC;
      end
      S_SUMACC: begin
        acc_nxt = cum;
        if (col_last) begin
          col_nxt = '0;
          if (cum > SUM_MIN) begin
            state_nxt = S_NRMRD;
          end else begin
            rem_nxt   = '0;
            lo_nxt    = {1'b1, {WB{1'b0}}};
            dvs_nxt   = SUMW'(n_eff);
            dcnt_nxt  = DCW'(QW);
            state_nxt = S_UDIV;
          end
        end else begin
          col_nxt   = col_r + SW'(1);
          state_nxt = S_SUMRD;
        end
      end

      // normalise each entry: w * one / sum
      S_NRMRD: begin
        state_nxt = S_NRMLD;
      end
      S_NRMLD: begin
        rem_nxt   = SUMW'(w_rdata >> 1);
        lo_nxt    = {w_rdata[0], {WB{1'b0}}};
        dvs_nxt   = acc_r;
        dcnt_nxt  = DCW'(QW);
        state_nxt = S_NDIV;
      end
      S_NRMWR: begin
        w_we    = 1'b1;
        w_wdata = q_sat;
        if (col_last) begin
          state_nxt = S_NOTERD;
        end else begin
          col_nxt   = col_r + SW'(1);
          state_nxt = S_NRMRD;
        end
      end

      // note search, lowest index wins
      S_SRCHRD: begin
        n_raddr   = col_r;
        state_nxt = S_SRCHCHK;
      end
      S_SRCHCHK: begin
        if (note_seen == note_r) begin
          cur_nxt   = col_r;
          state_nxt = S_NOTERD;
        end else if (col_last) begin
          cur_nxt   = '0;
          state_nxt = S_NOTERD;
        end else begin
          col_nxt   = col_r + SW'(1);
          state_nxt = S_SRCHRD;
        end
      end

      S_NOTERD: begin
        state_nxt = S_OUT;
      end

      S_OUT: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers; reset starts the uniform sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_UDIV;
      num_states_r <= 5'd16;
      cur_r        <= '0;
      prev_r       <= '0;
      col_r        <= '0;
      fill_r       <= '0;
      req_r        <= mns_pkg::REQ_FILL;
      status_r     <= 1'b0;
      rstp_r       <= 1'b1;
      note_vld_r   <= '0;
      rem_r        <= '0;
      lo_r         <= {1'b1, {WB{1'b0}}};
      dvs_r        <= SUMW'(NRST);
      dcnt_r       <= DCW'(QW);
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      prev_r     <= prev_nxt;
      col_r      <= col_nxt;
      fill_r     <= fill_nxt;
      req_r      <= req_nxt;
      status_r   <= status_nxt;
      rstp_r     <= rstp_nxt;
      note_vld_r <= note_vld_nxt;
      rem_r      <= rem_nxt;
      lo_r       <= lo_nxt;
      dvs_r      <= dvs_nxt;
      dcnt_r     <= dcnt_nxt;
      if (cfg_we) begin
        num_states_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wv_r   <= wv_nxt;
    rf_r   <= rf_nxt;
    note_r <= note_nxt;
    acc_r  <= acc_nxt;
    uni_r  <= uni_nxt;
    q_r    <= q_nxt;
  end

  // weight matrix, row-major
  mns_ram #(
    .WIDTH (WB),
    .DEPTH (1 << AW)
  ) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // note table
  mns_ram #(
    .WIDTH (7),
    .DEPTH (MAX_STATES)
  ) u_nram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (in_note_value),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  // result transfer
  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = (state_r == S_OUT);
  assign out_state_index  = 4'(cur_r);
  assign out_current_note = cur_ok ? note_seen : mns_pkg::NOTE_DFLT;
  assign out_status       = status_r;

endmodule

/* design/mns_checker.sv */
`include "markov_note_sampler_assert.svh"

module mns_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_req_type,
  input logic       out_strobe,
  input logic [3:0] out_state_index,
  input logic       out_status
);

  mns_pkg::req_t last_req_r;

  // request type of the last accepted transfer
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      last_req_r <= in_req_type;
    end
  end

  `MNS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `MNS_ASSERT_IMP(a_strobe_busy, out_strobe, busy)
  `MNS_ASSERT_NXT(a_strobe_once, out_strobe, !out_strobe && !busy)
  `MNS_ASSERT_IMP(a_fill_clears, out_strobe && last_req_r == mns_pkg::REQ_FILL, out_state_index == 4'd0 && !out_status)
  `MNS_ASSERT_IMP(a_bad_req, out_strobe && (last_req_r == mns_pkg::REQ_BAD_A || last_req_r == mns_pkg::REQ_BAD_B), out_status)

endmodule

bind markov_note_sampler mns_checker u_mns_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_req_type     (in_req_type),
  .out_strobe      (out_strobe),
  .out_state_index (out_state_index),
  .out_status      (out_status)
);

/* tb/tb_markov_note_sampler.sv */
`timescale 1ns / 100ps

// one request as presented on the input ports
typedef struct {
  mns_pkg::req_t req;
  logic [3:0]    from_idx;
  logic [3:0]    to_idx;
  logic [15:0]   wval;
  logic [15:0]   frac;
  logic [6:0]    note;
} note_req_t;

// one result as seen on the output ports
typedef struct {
  logic [3:0] state_idx;
  logic [6:0] cur_note;
  logic       status;
} note_res_t;

// chain predictor plus the queue of results still owed by the block
class chain_scoreboard;
  logic [4:0]  count_reg;
  logic [6:0]  notes [16];
  logic [15:0] wts [16][16];
  logic [3:0]  cur_st;
  logic [3:0]  prev_st;
  note_res_t   owed [$];

  function new();
    count_reg = 5'd16;
    cur_st = '0;
    prev_st = '0;
    foreach (notes[i]) notes[i] = '0;
    fill_rows();
  endfunction

  function int active_count();
    if (count_reg < 1) return 1;
    if (count_reg > 16) return 16;
    return int'(count_reg);
  endfunction

  function logic [15:0] even_weight(int n);
    int u;
    u = 65536 / n;
    return (u > 65535) ? 16'hffff : u[15:0];
  endfunction

  function void fill_rows();
    logic [15:0] u;
    u = even_weight(active_count());
    foreach (wts[i, j]) wts[i][j] = u;
  endfunction

  // scale each row entry by one over the row total, or flatten a tiny row
  function void rescale_row(int r, int n);
    longint total;
    longint q;
    total = 0;
    for (int j = 0; j < n; j++) total += wts[r][j];
    if (total * 10000 > 65536) begin
      for (int j = 0; j < n; j++) begin
        q = (longint'(wts[r][j]) * 65536) / total;
        wts[r][j] = (q > 65535) ? 16'hffff : q[15:0];
      end
    end else begin
      for (int j = 0; j < n; j++) wts[r][j] = even_weight(n);
    end
  endfunction

  function void write_count(logic [4:0] v);
    count_reg = v;
  endfunction

  // apply one accepted request and queue the result it must produce
  function void note_request(note_req_t r);
    int n;
    logic st;
    longint cum;
    longint w;
    int pick;
    int found;
    note_res_t e;
    n = active_count();
    st = 1'b0;
    case (r.req)
      mns_pkg::REQ_WR_NOTE: begin
        if (r.from_idx < n) notes[r.from_idx] = r.note;
        else st = 1'b1;
      end
      mns_pkg::REQ_WR_WT: begin
        if (r.from_idx < n && r.to_idx < n) wts[r.from_idx][r.to_idx] = r.wval;
        else st = 1'b1;
      end
      mns_pkg::REQ_STEP: begin
        if (cur_st < n) begin
          cum = 0;
          pick = n - 1;
          prev_st = cur_st;
          for (int j = 0; j < n; j++) begin
            cum += wts[cur_st][j];
            if (longint'(r.frac) < cum) begin
              pick = j;
              break;
            end
          end
          cur_st = pick[3:0];
        end else st = 1'b1;
      end
      mns_pkg::REQ_REINF: begin
        if (prev_st < n && cur_st < n) begin
          w = longint'(wts[prev_st][cur_st]) + r.wval;
          wts[prev_st][cur_st] = (w > 65535) ? 16'hffff : w[15:0];
          rescale_row(prev_st, n);
        end else st = 1'b1;
      end
      mns_pkg::REQ_SET_NOTE: begin
        found = 0;
        for (int j = 0; j < n; j++) begin
          if (notes[j] == r.note) begin
            found = j;
            break;
          end
        end
        cur_st = found[3:0];
      end
      mns_pkg::REQ_FILL: begin
        fill_rows();
        cur_st = '0;
        prev_st = '0;
      end
      default: st = 1'b1;
    endcase
    e.state_idx = cur_st;
    e.cur_note = (cur_st < n) ? notes[cur_st] : mns_pkg::NOTE_DFLT;
    e.status = st;
    owed.push_back(e);
  endfunction

  // compare against the oldest owed result; returns a message, empty when clean
  function string check_result(note_res_t got);
    note_res_t e;
    string msg;
    msg = "";
    if (owed.size() == 0) return "result with nothing owed";
    e = owed.pop_front();
    if (got.state_idx !== e.state_idx)
      msg = {msg, $sformatf(" state %0d/%0d", got.state_idx, e.state_idx)};
    if (got.cur_note !== e.cur_note)
      msg = {msg, $sformatf(" note %0d/%0d", got.cur_note, e.cur_note)};
    if (got.status !== e.status)
      msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
    return msg;
  endfunction
endclass

module tb_markov_note_sampler;
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_req_type;
  logic [3:0]  in_from_index;
  logic [3:0]  in_to_index;
  logic [15:0] in_weight_value;
  logic [15:0] in_random_fraction;
  logic [6:0]  in_note_value;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        out_strobe;
  logic [3:0]  out_state_index;
  logic [6:0]  out_current_note;
  logic        out_status;

  chain_scoreboard sb;
  int  err_count;
  bit  idle_on;

  markov_note_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_from_index(in_from_index),
    .in_to_index(in_to_index), .in_weight_value(in_weight_value),
    .in_random_fraction(in_random_fraction), .in_note_value(in_note_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_state_index(out_state_index),
    .out_current_note(out_current_note), .out_status(out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report(string msg);
    $display("mismatch @%0t:%s", $realtime, msg);
    err_count++;
  endtask

  // result monitor
  always @(posedge clk) begin
    note_res_t got;
    string msg;
    if (rst_n && out_strobe) begin
      got.state_idx = out_state_index;
      got.cur_note = out_current_note;
      got.status = out_status;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  // present one request and hold it until the transfer happens
  task automatic send(note_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk);
    in_req_type = r.req;
    in_from_index = r.from_idx;
    in_to_index = r.to_idx;
    in_weight_value = r.wval;
    in_random_fraction = r.frac;
    in_note_value = r.note;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_fields(mns_pkg::req_t q, int f, int t, int w, int fr, int nt);
    note_req_t r;
    r.req = q;
    r.from_idx = 4'(f);
    r.to_idx = 4'(t);
    r.wval = 16'(w);
    r.frac = 16'(fr);
    r.note = 7'(nt);
    send(r);
  endtask

  // wait for the block to drain, then write the state count
  task automatic set_count(logic [4:0] v);
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    sb.write_count(v);
    cfg_we = 1'b0;
  endtask

  // random request biased toward in-range indexes and repeated notes
  function automatic note_req_t rand_request(int n);
    note_req_t r;
    int pct;
    pct = $urandom_range(0, 99);
    r.from_idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                 4'($urandom_range(0, n - 1));
    r.to_idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
               4'($urandom_range(0, n - 1));
    r.wval = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 64)) :
             16'($urandom_range(0, 65535));
    r.frac = 16'($urandom_range(0, 65535));
    r.note = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
             7'($urandom_range(0, 7));
    if (pct < 12) r.req = mns_pkg::REQ_WR_NOTE;
    else if (pct < 24) r.req = mns_pkg::REQ_WR_WT;
    else if (pct < 55) r.req = mns_pkg::REQ_STEP;
    else if (pct < 75) r.req = mns_pkg::REQ_REINF;
    else if (pct < 89) r.req = mns_pkg::REQ_SET_NOTE;
    else if (pct < 93) r.req = mns_pkg::REQ_FILL;
    else if (pct < 95) r.req = mns_pkg::REQ_BAD_A;
    else if (pct < 97) r.req = mns_pkg::REQ_BAD_B;
    else begin
      r.req = mns_pkg::REQ_WR_WT;
      r.wval = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
    end
    return r;
  endfunction

  initial begin
    logic [4:0] phases [8];
    err_count = 0;
    idle_on = 1'b1;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 5'd16;
    in_req_type = mns_pkg::REQ_WR_NOTE;
    in_from_index = '0;
    in_to_index = '0;
    in_weight_value = '0;
    in_random_fraction = '0;
    in_note_value = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every request type and a note-search miss
    send_fields(mns_pkg::REQ_SET_NOTE, 0, 0, 0, 0, 0);
    send_fields(mns_pkg::REQ_WR_NOTE, 0, 0, 0, 0, 127);
    send_fields(mns_pkg::REQ_WR_NOTE, 15, 0, 0, 0, 1);
    send_fields(mns_pkg::REQ_SET_NOTE, 0, 0, 0, 0, 1);
    send_fields(mns_pkg::REQ_SET_NOTE, 0, 0, 0, 0, 99);
    send_fields(mns_pkg::REQ_WR_WT, 15, 15, 65535, 0, 0);
    send_fields(mns_pkg::REQ_WR_WT, 0, 15, 0, 0, 0);
    send_fields(mns_pkg::REQ_STEP, 0, 0, 0, 65535, 0);
    send_fields(mns_pkg::REQ_STEP, 0, 0, 0, 0, 0);
    send_fields(mns_pkg::REQ_REINF, 0, 0, 65535, 0, 0);
    send_fields(mns_pkg::REQ_BAD_A, 15, 15, 65535, 65535, 127);
    send_fields(mns_pkg::REQ_BAD_B, 0, 0, 0, 0, 0);
    send_fields(mns_pkg::REQ_FILL, 0, 0, 0, 0, 0);

    // small count: out-of-range writes and a near-empty row that flattens
    set_count(5'd4);
    send_fields(mns_pkg::REQ_FILL, 0, 0, 0, 0, 0);
    send_fields(mns_pkg::REQ_WR_NOTE, 4, 0, 0, 0, 5);
    send_fields(mns_pkg::REQ_WR_WT, 0, 4, 100, 0, 0);
    for (int j = 0; j < 4; j++) send_fields(mns_pkg::REQ_WR_WT, 0, j, 0, 0, 0);
    send_fields(mns_pkg::REQ_REINF, 0, 0, 3, 0, 0);
    send_fields(mns_pkg::REQ_STEP, 0, 0, 0, 65535, 0);
    // stale state after the count drops
    set_count(5'd16);
    send_fields(mns_pkg::REQ_WR_WT, 0, 15, 65535, 0, 0);
    send_fields(mns_pkg::REQ_STEP, 0, 0, 0, 65535, 0);
    set_count(5'd2);
    send_fields(mns_pkg::REQ_STEP, 0, 0, 0, 0, 0);
    send_fields(mns_pkg::REQ_REINF, 0, 0, 10, 0, 0);

    // random phases over several counts, extremes included
    phases[0] = 5'd16;
    phases[1] = 5'd1;
    phases[2] = 5'd0;
    phases[3] = 5'd31;
    phases[4] = 5'($urandom_range(2, 15));
    phases[5] = 5'd17;
    phases[6] = 5'($urandom_range(2, 15));
    phases[7] = 5'd16;
    foreach (phases[p]) begin
      int n;
      set_count(phases[p]);
      n = sb.active_count();
      if (p == 7) idle_on = 1'b0;
      if ($urandom_range(0, 1) == 0) send_fields(mns_pkg::REQ_FILL, 0, 0, 0, 0, 0);
      for (int i = 0; i < n; i++)
        send_fields(mns_pkg::REQ_WR_NOTE, i, 0, 0, 0, int'($urandom_range(0, 7)));
      repeat (185) send(rand_request(n));
    end

    while (sb.owed.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (err_count == 0 && sb.owed.size() == 0) begin
      $display("PASS markov_note_sampler");
    end else begin
      $display("FAIL markov_note_sampler");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("FAIL markov_note_sampler");
    $finish;
  end
endmodule
